@@ sv/alr_pkg.sv @@
`timescale 1ns / 1ps

package alr_pkg;

   localparam int PIX_W   = 7;
   localparam int IN_W    = 6;
   localparam int COLOR_W = 24;
   localparam int COVER_W = 8;

   localparam logic [COVER_W-1:0] COVER_HALF = 8'd128;
   localparam logic [COVER_W-1:0] COVER_FULL = 8'd255;
   localparam logic [COVER_W-1:0] COVER_NONE = 8'd0;

   typedef struct packed {
      logic [IN_W-1:0]    start_x;
      logic [IN_W-1:0]    start_y;
      logic [IN_W-1:0]    end_x;
      logic [IN_W-1:0]    end_y;
      logic [COLOR_W-1:0] line_color;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel_x;
      logic [PIX_W-1:0]   pixel_y;
      logic               along_x;
      logic [COVER_W-1:0] cover_first;
      logic [COVER_W-1:0] cover_second;
      logic [COLOR_W-1:0] pixel_color;
      logic               last;
   } rsp_type;

endpackage

@@ sv/alr_div.sv @@
`timescale 1ns / 1ps

module alr_div #(
   parameter int COORD_BITS = 6,
   parameter int FRAC_BITS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [COORD_BITS+FRAC_BITS-1:0] dividend,
   input  logic [COORD_BITS-1:0]           divisor,
   output logic                            done,
   output logic [FRAC_BITS:0]              quotient
);
   localparam int CB    = COORD_BITS;
   localparam int DVD_W = COORD_BITS + FRAC_BITS;
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CB-1:0]    rem_ff;
   logic [DVD_W-1:0] dvd_ff;
   logic [DVD_W-1:0] quo_ff;

   logic [CB:0]      trial;
   logic [CB:0]      diff;
   logic             qbit_in;
   logic [CB-1:0]    rem_in;

   // one restoring step: bring down the next dividend bit, subtract if it fits
   always_comb begin
      trial   = {rem_ff, dvd_ff[DVD_W-1]};
      diff    = trial - {1'b0, divisor};
      qbit_in = (trial >= {1'b0, divisor});
      rem_in  = qbit_in ? diff[CB-1:0] : trial[CB-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= busy_ff && !start && (count_ff == CNT_W'(1));
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_W'(DVD_W);
            rem_ff   <= '0;
            dvd_ff   <= dividend;
            quo_ff   <= '0;
         end else if (busy_ff) begin
            rem_ff   <= rem_in;
            dvd_ff   <= {dvd_ff[DVD_W-2:0], 1'b0};
            quo_ff   <= {quo_ff[DVD_W-2:0], qbit_in};
            count_ff <= count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff[FRAC_BITS:0];

endmodule

@@ sv/antialiased_line_raster_core.sv @@
`timescale 1ns / 1ps
// From the request transfer to the first result: divider load, COORD_BITS+FRAC_BITS divider
// steps, done register, then the output register, which waits for a free output slot.
// Results then follow at one per cycle while rsp_ready is high.
// One line at a time (req_ready only in idle), N = 2..2^COORD_BITS results per line, from the
// bit-serial gradient divider and the single column stepper. Zero-length lines skip the divide.
// Reset: synchronous, clears the sequencer and the output valid; no memories to clear.
module antialiased_line_raster_core #(
   parameter int COORD_BITS = 6,
   parameter int FRAC_BITS  = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  alr_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output alr_pkg::rsp_type rsp_data
);
   import alr_pkg::*;

   localparam int CB      = COORD_BITS;
   localparam int FB      = FRAC_BITS;
   localparam int DVD_W   = CB + FB;
   localparam int SLOPE_W = FB + 2;
   localparam int ACC_W   = CB + FB + 2;
   localparam int PROD_W  = FB + 9;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_START,
      ST_END,
      ST_INNER
   } state_type;

   state_type state_ff;

   logic [CB-1:0]  a0_ff, b0_ff, a1_ff, b1_ff;
   logic [CB-1:0]  dx_ff;
   logic [CB-1:0]  dy_mag_ff;
   logic           dy_neg_ff;
   logic           steep_ff;
   logic [COLOR_W-1:0] color_ff;
   logic signed [SLOPE_W-1:0] slope_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic [CB-1:0]  column_ff;
   logic           div_start_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_data_ff;

   // request decode
   logic [CB-1:0] sx, sy, ex, ey, adx, ady;
   logic          steep_in;
   logic [CB-1:0] ma0, mb0, ma1, mb1;
   logic          swap;
   logic [CB-1:0] a0_in, b0_in, a1_in, b1_in, dx_in, dy_mag_in;
   logic          dy_neg_in;

   always_comb begin
      sx        = req_data.start_x[CB-1:0];
      sy        = req_data.start_y[CB-1:0];
      ex        = req_data.end_x[CB-1:0];
      ey        = req_data.end_y[CB-1:0];
      adx       = (ex > sx) ? ex - sx : sx - ex;
      ady       = (ey > sy) ? ey - sy : sy - ey;
      steep_in  = (ady > adx);
      ma0       = steep_in ? sy : sx;
      mb0       = steep_in ? sx : sy;
      ma1       = steep_in ? ey : ex;
      mb1       = steep_in ? ex : ey;
      swap      = (ma0 > ma1);
      a0_in     = swap ? ma1 : ma0;
      b0_in     = swap ? mb1 : mb0;
      a1_in     = swap ? ma0 : ma1;
      b1_in     = swap ? mb0 : mb1;
      dx_in     = a1_in - a0_in;
      dy_neg_in = (b1_in < b0_in);
      dy_mag_in = dy_neg_in ? b0_in - b1_in : b1_in - b0_in;
   end

   // gradient divider
   logic               div_done;
   logic [FB:0]        div_quot;
   logic [DVD_W-1:0]   div_dividend;

   assign div_dividend = {dy_mag_ff, {FB{1'b0}}};

   alr_div #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dividend),
      .divisor  (dx_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // column stepper
   logic [SLOPE_W-1:0]      quot_ext;
   logic signed [SLOPE_W-1:0] slope_in;
   logic signed [ACC_W-1:0] slope_in_ext, slope_ff_ext;
   logic signed [ACC_W-1:0] acc_base_in;
   logic signed [ACC_W-1:0] acc_init_in;
   logic signed [ACC_W-1:0] acc_clamp;
   logic signed [ACC_W-1:0] acc_in;
   logic [FB-1:0]           frac;
   logic [PROD_W-1:0]       prod;
   logic [COVER_W-1:0]      cover2;
   logic [CB-1:0]           minor;
   logic                    inner_last;
   logic                    short_line;
   logic                    out_free;
   logic                    rsp_load;

   always_comb begin
      quot_ext     = {1'b0, div_quot};
      slope_in     = $signed(dy_neg_ff ? (~quot_ext + SLOPE_W'(1)) : quot_ext);
      slope_in_ext = {{(ACC_W-SLOPE_W){slope_in[SLOPE_W-1]}}, slope_in};
      slope_ff_ext = {{(ACC_W-SLOPE_W){slope_ff[SLOPE_W-1]}}, slope_ff};
      acc_base_in  = $signed({2'b00, b0_ff, {FB{1'b0}}});
      acc_init_in  = acc_base_in + slope_in_ext;
      // clamp below zero, then take floor and fraction
      acc_clamp    = acc_ff[ACC_W-1] ? '0 : acc_ff;
      acc_in       = acc_clamp + slope_ff_ext;
      frac         = acc_clamp[FB-1:0];
      prod         = (PROD_W'(frac) << 8) - PROD_W'(frac) + (PROD_W'(1) << (FB-1));
      cover2       = prod[FB+7:FB];
      minor        = acc_clamp[FB+CB-1:FB];
      inner_last   = ({1'b0, column_ff} + (CB+1)'(1)) == {1'b0, a1_ff};
      short_line   = (dx_ff < CB'(2));
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_load     = out_free && ((state_ff == ST_START) || (state_ff == ST_END) ||
                                  (state_ff == ST_INNER));
   end

   function automatic rsp_type make_rsp(input logic steep,
                                        input logic [CB-1:0] major,
                                        input logic [CB-1:0] minor_c,
                                        input logic [COVER_W-1:0] c1,
                                        input logic [COVER_W-1:0] c2,
                                        input logic [COLOR_W-1:0] color,
                                        input logic is_last);
      rsp_type r;
      r.pixel_x      = steep ? PIX_W'(minor_c) : PIX_W'(major);
      r.pixel_y      = steep ? PIX_W'(major) : PIX_W'(minor_c);
      r.along_x      = steep;
      r.cover_first  = c1;
      r.cover_second = c2;
      r.pixel_color  = color;
      r.last         = is_last;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= (state_ff == ST_IDLE) && req_valid && (dx_in != '0);
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  a0_ff     <= a0_in;
                  b0_ff     <= b0_in;
                  a1_ff     <= a1_in;
                  b1_ff     <= b1_in;
                  dx_ff     <= dx_in;
                  dy_mag_ff <= dy_mag_in;
                  dy_neg_ff <= dy_neg_in;
                  steep_ff  <= steep_in;
                  color_ff  <= req_data.line_color;
                  if (dx_in == '0) begin
                     // zero-length line: gradient 0, no divide
                     slope_ff <= '0;
                     acc_ff   <= $signed({2'b00, b0_in, {FB{1'b0}}});
                     state_ff <= ST_START;
                  end else begin
                     state_ff <= ST_DIVIDE;
                  end
               end
            end
            ST_DIVIDE: begin
               if (div_done) begin
                  slope_ff <= slope_in;
                  acc_ff   <= acc_init_in;
                  state_ff <= ST_START;
               end
            end
            ST_START: begin
               if (out_free) begin
                  rsp_data_ff  <= make_rsp(steep_ff, a0_ff, b0_ff, COVER_HALF, COVER_NONE,
                                           color_ff, 1'b0);
                  state_ff     <= ST_END;
               end
            end
            ST_END: begin
               if (out_free) begin
                  rsp_data_ff  <= make_rsp(steep_ff, a1_ff, b1_ff, COVER_HALF, COVER_NONE,
                                           color_ff, short_line);
                  column_ff    <= a0_ff + CB'(1);
                  state_ff     <= short_line ? ST_IDLE : ST_INNER;
               end
            end
            ST_INNER: begin
               if (out_free) begin
                  rsp_data_ff  <= make_rsp(steep_ff, column_ff, minor, COVER_FULL - cover2,
                                           cover2, color_ff, inner_last);
                  acc_ff       <= acc_in;
                  column_ff    <= column_ff + CB'(1);
                  if (inner_last) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
